@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/rld_pkg.sv @@
// constants, codes, types and ring helpers of the run length deque
package rld_pkg;

    localparam int CAPACITY    = 256;
    localparam int VALUE_BITS  = 32;
    localparam int ITEM_BITS   = 32;
    localparam int MODE_BITS   = 3;
    localparam int STATUS_BITS = 2;
    localparam int IDX_BITS    = $clog2(CAPACITY);
    localparam int CNT_BITS    = $clog2(CAPACITY + 1);
    localparam int WORD_BITS   = VALUE_BITS + CNT_BITS;

    localparam logic [MODE_BITS-1:0] MODE_PUSH_FRONT  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_PUSH_BACK   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_POP_FRONT   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_POP_BACK    = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_QUERY_LEFT  = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_QUERY_RIGHT = 3'd5;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                 en;
        logic [IDX_BITS-1:0]  addr;
        logic [WORD_BITS-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [CNT_BITS-1:0]    run_length;
    } result_t;

    function automatic logic [IDX_BITS-1:0] ring_next(input logic [IDX_BITS-1:0] i);
        return (i == IDX_BITS'(CAPACITY - 1)) ? '0 : i + IDX_BITS'(1);
    endfunction

    function automatic logic [IDX_BITS-1:0] ring_prev(input logic [IDX_BITS-1:0] i);
        return (i == '0) ? IDX_BITS'(CAPACITY - 1) : i - IDX_BITS'(1);
    endfunction

endpackage

@@ rtl/rld_ram.sv @@
// generic single write port ram with registered read
module rld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/rld_ctrl.sv @@
// sequencer: end indices, totals and read-modify-write of the run store
module rld_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rld_pkg::MODE_BITS-1:0]  s_mode,
    input  logic signed [rld_pkg::ITEM_BITS-1:0] s_item_value,
    output logic                           rd_en,
    output logic [rld_pkg::IDX_BITS-1:0]   rd_addr,
    input  logic [rld_pkg::WORD_BITS-1:0]  rd_data,
    output rld_pkg::mem_wr_t               mem_wr,
    output logic                           res_valid,
    input  logic                           res_ready,
    output rld_pkg::result_t               res
);
    import rld_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                  state_reg, state_next;
    logic [MODE_BITS-1:0]  mode_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [IDX_BITS-1:0]   front_reg, front_next;
    logic [IDX_BITS-1:0]   back_reg, back_next;
    logic [CNT_BITS-1:0]   runs_reg, runs_next;
    logic [CNT_BITS-1:0]   elems_reg, elems_next;

    logic [VALUE_BITS-1:0] rd_value;
    logic [CNT_BITS-1:0]   rd_count;
    logic                  at_front;
    logic [IDX_BITS-1:0]   end_idx;
    logic                  fire;

    assign s_ready  = (state_reg == ST_IDLE);
    assign rd_en    = s_valid && s_ready;
    assign rd_value = rd_data[VALUE_BITS-1:0];
    assign rd_count = rd_data[VALUE_BITS +: CNT_BITS];
    assign fire     = (state_reg == ST_EXEC) && res_ready;
    assign res_valid = fire;
    assign at_front = (mode_reg == MODE_PUSH_FRONT) || (mode_reg == MODE_POP_FRONT);
    assign end_idx  = at_front ? front_reg : back_reg;

    always_comb begin
        case (s_mode) inside
            MODE_PUSH_BACK, MODE_POP_BACK, MODE_QUERY_RIGHT: rd_addr = back_reg;
            default:                                         rd_addr = front_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        front_next = front_reg;
        back_next  = back_reg;
        runs_next  = runs_reg;
        elems_next = elems_reg;
        mem_wr     = '0;
        res        = '0;
        res.status = STATUS_OK;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                    case (mode_reg) inside
                        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                            if (elems_reg >= CNT_BITS'(CAPACITY)) begin
                                res.status = STATUS_FULL;
                            end else begin
                                elems_next = elems_reg + CNT_BITS'(1);
                                mem_wr.en  = 1'b1;
                                if (runs_reg == '0) begin
                                    back_next   = front_reg;
                                    mem_wr.addr = front_reg;
                                    mem_wr.data = {CNT_BITS'(1), value_reg};
                                    runs_next   = CNT_BITS'(1);
                                end else if (rd_value == value_reg) begin
                                    mem_wr.addr = end_idx;
                                    mem_wr.data = {rd_count + CNT_BITS'(1), rd_value};
                                end else begin
                                    if (at_front) begin
                                        front_next  = ring_prev(front_reg);
                                        mem_wr.addr = ring_prev(front_reg);
                                    end else begin
                                        back_next   = ring_next(back_reg);
                                        mem_wr.addr = ring_next(back_reg);
                                    end
                                    mem_wr.data = {CNT_BITS'(1), value_reg};
                                    runs_next   = runs_reg + CNT_BITS'(1);
                                end
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK: begin
                            if (elems_reg == '0) begin
                                res.status = STATUS_EMPTY;
                            end else begin
                                elems_next = elems_reg - CNT_BITS'(1);
                                if (rd_count <= CNT_BITS'(1) || elems_reg == CNT_BITS'(1)) begin
                                    runs_next = runs_reg - CNT_BITS'(1);
                                    if (runs_reg != CNT_BITS'(1)) begin
                                        if (at_front) begin
                                            front_next = ring_next(front_reg);
                                        end else begin
                                            back_next = ring_prev(back_reg);
                                        end
                                    end
                                end else begin
                                    mem_wr.en   = 1'b1;
                                    mem_wr.addr = end_idx;
                                    mem_wr.data = {rd_count - CNT_BITS'(1), rd_value};
                                end
                            end
                        end
                        MODE_QUERY_LEFT, MODE_QUERY_RIGHT: begin
                            if (runs_reg != '0) begin
                                res.run_length = rd_count;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            front_reg <= '0;
            back_reg  <= '0;
            runs_reg  <= '0;
            elems_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (fire) begin
                front_reg <= front_next;
                back_reg  <= back_next;
                runs_reg  <= runs_next;
                elems_reg <= elems_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mode_reg  <= s_mode;
            value_reg <= s_item_value[VALUE_BITS-1:0];
        end
    end

endmodule

@@ rtl/run_length_deque.sv @@
// top level: run store ram, sequencer and result register
// result path: store read, then write-back, which also loads the output register that drives m_valid
// the sequencer takes no new item until the read-then-write pass on the run store for the last one is done
// a result waiting in the output register holds the write-back and so blocks the next input transfer
// reset: synchronous active-low aresetn clears indices, totals and handshake state
// reset: run store contents stay undefined; no clearing pass, ready right after reset
`include "assert_macros.svh"

module run_length_deque (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rld_pkg::MODE_BITS-1:0]        s_mode,
    input  logic signed [rld_pkg::ITEM_BITS-1:0] s_item_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rld_pkg::STATUS_BITS-1:0]      m_status,
    output logic [rld_pkg::CNT_BITS-1:0]         m_run_length
);
    import rld_pkg::*;

    logic                 rd_en;
    logic [IDX_BITS-1:0]  rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    mem_wr_t              mem_wr;
    logic                 res_valid;
    logic                 res_ready;
    result_t              res;

    logic                   m_valid_reg;
    logic [STATUS_BITS-1:0] m_status_reg;
    logic [CNT_BITS-1:0]    m_run_length_reg;

    rld_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_run_store (
        .aclk    (aclk),
        .wr_en   (mem_wr.en),
        .wr_addr (mem_wr.addr),
        .wr_data (mem_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rld_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_item_value (s_item_value),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .mem_wr       (mem_wr),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // output slot is free when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_status_reg     <= res.status;
            m_run_length_reg <= res.run_length;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_run_length = m_run_length_reg;

    `ASSERT_SAME(a_res_fits, aclk, aresetn, res_valid, res_ready)
    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ASSERT_SAME(a_err_no_len, aclk, aresetn, res_valid && res.status != STATUS_OK, res.run_length == '0)

endmodule

@@ dv/tb_run_length_deque.sv @@
// self-checking testbench for the run length deque: directed and random ops against a predictor
`timescale 1ns / 1ps

module tb_run_length_deque;
    import rld_pkg::*;

    localparam logic [MODE_BITS-1:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [MODE_BITS-1:0] MODE_UNUSED_7 = 3'd7;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int HOLDOFF_AFTER = 100;

    typedef struct {
        logic [MODE_BITS-1:0] mode;
        logic [ITEM_BITS-1:0] value;
        bit                   hold;
    } deque_op_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [MODE_BITS-1:0]        s_mode;
    logic signed [ITEM_BITS-1:0] s_item_value;
    logic                        m_valid;
    logic                        m_ready;
    logic [STATUS_BITS-1:0]      m_status;
    logic [CNT_BITS-1:0]         m_run_length;

    run_length_deque u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_run_length (m_run_length)
    );

    // predicted deque contents
    logic [VALUE_BITS-1:0] run_val [CAPACITY];
    logic [CNT_BITS-1:0]   run_cnt [CAPACITY];
    logic [IDX_BITS-1:0]   front_idx;
    logic [IDX_BITS-1:0]   back_idx;
    logic [CNT_BITS-1:0]   runs_held;
    logic [CNT_BITS-1:0]   elems_held;

    deque_op_t stim_items[$];
    result_t   awaited_results[$];
    logic [ITEM_BITS-1:0] value_pool [4];
    int gen_elems;
    int errors;
    int results_seen;
    int burst_left;
    int gap_left;
    int holdoff_left;
    bit holdoff_done;
    int pattern_kind;
    int pattern_left;
    int idle_cycles;

    function automatic result_t deque_apply(input logic [MODE_BITS-1:0] mode,
                                            input logic [ITEM_BITS-1:0] item);
        result_t               res;
        logic [IDX_BITS-1:0]   slot;
        logic [VALUE_BITS-1:0] val;
        bit                    at_front;
        res.status = STATUS_OK;
        res.run_length = '0;
        val = item[VALUE_BITS-1:0];
        at_front = (mode == MODE_PUSH_FRONT || mode == MODE_POP_FRONT);
        slot = at_front ? front_idx : back_idx;
        case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (elems_held >= CNT_BITS'(CAPACITY)) begin
                    res.status = STATUS_FULL;
                end else begin
                    if (runs_held == 0) begin
                        back_idx = front_idx;
                        run_val[front_idx] = val;
                        run_cnt[front_idx] = CNT_BITS'(1);
                        runs_held = CNT_BITS'(1);
                    end else if (run_val[slot] == val) begin
                        run_cnt[slot] = run_cnt[slot] + 1'b1;
                    end else begin
                        if (at_front) begin
                            front_idx = (front_idx == '0) ? IDX_BITS'(CAPACITY - 1)
                                                          : front_idx - 1'b1;
                            slot = front_idx;
                        end else begin
                            back_idx = (back_idx == IDX_BITS'(CAPACITY - 1)) ? '0
                                                                             : back_idx + 1'b1;
                            slot = back_idx;
                        end
                        run_val[slot] = val;
                        run_cnt[slot] = CNT_BITS'(1);
                        runs_held = runs_held + 1'b1;
                    end
                    elems_held = elems_held + 1'b1;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
                if (elems_held == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    elems_held = elems_held - 1'b1;
                    if (run_cnt[slot] <= 1 || elems_held == 0) begin
                        run_cnt[slot] = '0;
                        runs_held = runs_held - 1'b1;
                        if (runs_held != 0) begin
                            if (at_front)
                                front_idx = (front_idx == IDX_BITS'(CAPACITY - 1)) ? '0
                                                                                   : front_idx + 1'b1;
                            else
                                back_idx = (back_idx == '0) ? IDX_BITS'(CAPACITY - 1)
                                                            : back_idx - 1'b1;
                        end
                    end else begin
                        run_cnt[slot] = run_cnt[slot] - 1'b1;
                    end
                end
            end
            MODE_QUERY_LEFT: begin
                if (runs_held != 0) res.run_length = run_cnt[front_idx];
            end
            MODE_QUERY_RIGHT: begin
                if (runs_held != 0) res.run_length = run_cnt[back_idx];
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic add_op(input logic [MODE_BITS-1:0] mode, input logic [ITEM_BITS-1:0] value,
                          input bit hold);
        deque_op_t op;
        op.mode = mode;
        op.value = value;
        op.hold = hold;
        stim_items = {stim_items, op};
        if ((mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK) && gen_elems < CAPACITY)
            gen_elems++;
        else if ((mode == MODE_POP_FRONT || mode == MODE_POP_BACK) && gen_elems > 0)
            gen_elems--;
    endtask

    task automatic add_random(input int push_pct, input int pop_pct, input bit single,
                              input bit hold);
        int r;
        int q;
        logic [MODE_BITS-1:0] mode;
        logic [ITEM_BITS-1:0] value;
        r = $urandom_range(0, 99);
        q = $urandom_range(0, 9);
        if (r < push_pct)
            mode = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        else if (r < push_pct + pop_pct)
            mode = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
        else if (q < 4)
            mode = MODE_QUERY_LEFT;
        else if (q < 8)
            mode = MODE_QUERY_RIGHT;
        else
            mode = (q == 8) ? MODE_UNUSED_6 : MODE_UNUSED_7;
        if (single)
            value = value_pool[0];
        else if ($urandom_range(0, 99) < 70)
            value = value_pool[$urandom_range(0, 3)];
        else
            value = $urandom;
        add_op(mode, value, hold);
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = MODE_QUERY_LEFT;
        s_item_value = '0;
        m_ready = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            run_val[i] = '0;
            run_cnt[i] = '0;
        end
        front_idx = '0;
        back_idx = '0;
        runs_held = '0;
        elems_held = '0;
        gen_elems = 0;
        errors = 0;
        results_seen = 0;
        burst_left = 1;
        gap_left = 0;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        pattern_kind = 0;
        pattern_left = 0;
        idle_cycles = 0;
    end

    always #5 aclk = ~aclk;

    initial begin
        value_pool[0] = $urandom;
        value_pool[1] = value_pool[0] ^ 32'h0000_0001;
        value_pool[2] = value_pool[0] ^ 32'h8000_0000;
        value_pool[3] = ~value_pool[0];

        // empty deque, unused modes, runs at both ends, values one bit apart
        add_op(MODE_POP_FRONT, 32'h0, 1'b0);
        add_op(MODE_POP_BACK, 32'hFFFF_FFFF, 1'b0);
        add_op(MODE_QUERY_LEFT, 32'h0, 1'b0);
        add_op(MODE_QUERY_RIGHT, 32'h0, 1'b0);
        add_op(MODE_UNUSED_6, 32'hFFFF_FFFF, 1'b0);
        add_op(MODE_UNUSED_7, 32'h0, 1'b0);
        add_op(MODE_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0);
        add_op(MODE_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0);
        add_op(MODE_QUERY_LEFT, 32'h0, 1'b0);
        add_op(MODE_PUSH_BACK, 32'h8000_0000, 1'b0);
        add_op(MODE_PUSH_BACK, 32'h8000_0001, 1'b0);
        add_op(MODE_PUSH_BACK, 32'h8000_0001, 1'b0);
        add_op(MODE_QUERY_RIGHT, 32'h0, 1'b0);
        add_op(MODE_QUERY_LEFT, 32'h0, 1'b0);
        add_op(MODE_PUSH_FRONT, 32'h0000_0000, 1'b0);
        add_op(MODE_QUERY_LEFT, 32'h0, 1'b0);
        add_op(MODE_POP_BACK, 32'h0, 1'b0);
        add_op(MODE_POP_BACK, 32'h0, 1'b0);
        add_op(MODE_QUERY_RIGHT, 32'h0, 1'b0);
        add_op(MODE_POP_FRONT, 32'h0, 1'b0);
        add_op(MODE_POP_FRONT, 32'h0, 1'b0);
        add_op(MODE_QUERY_LEFT, 32'h0, 1'b0);
        add_op(MODE_POP_BACK, 32'h0, 1'b0);
        add_op(MODE_POP_FRONT, 32'h0, 1'b0);
        add_op(MODE_QUERY_LEFT, 32'h0, 1'b0);

        // fill with one value up to capacity, then push against the full deque
        add_random(96, 2, 1'b1, 1'b1);
        while (gen_elems < CAPACITY) add_random(96, 2, 1'b1, 1'b0);
        repeat (12) add_random(60, 0, 1'b1, 1'b0);
        // drain to empty, then pop against the empty deque
        add_random(2, 96, 1'b0, 1'b1);
        while (gen_elems > 0) add_random(2, 96, 1'b0, 1'b0);
        repeat (12) add_random(0, 60, 1'b0, 1'b0);
        // mixed values near empty so the ring indices wrap both ways
        add_random(45, 40, 1'b0, 1'b1);
        repeat (150) add_random(45, 40, 1'b0, 1'b0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (stim_items.size() != 0 || s_valid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (awaited_results.size() != 0) begin
            $display("%0t %0d results never arrived", $time, awaited_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // driver
    always @(posedge aclk) begin : driver
        deque_op_t op;
        result_t   pred;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pred = deque_apply(s_mode, s_item_value);
                awaited_results = {awaited_results, pred};
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (stim_items.size() == 0 ||
                             (stim_items[0].hold && awaited_results.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    op = stim_items[0];
                    stim_items.delete(0);
                    s_mode <= op.mode;
                    s_item_value <= op.value;
                    s_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
            end
        end
    end

    // receiver stall pattern with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_kind = $urandom_range(0, 2);
                pattern_left = $urandom_range(16, 96);
            end else begin
                pattern_left--;
            end
            case (pattern_kind)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin : monitor
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                $display("%0t unexpected transfer: status %0d run_length %0d",
                         $time, m_status, m_run_length);
                errors++;
            end else begin
                want = awaited_results[0];
                awaited_results.delete(0);
                if (m_status !== want.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, want.status, m_status);
                    errors++;
                end
                if (m_run_length !== want.run_length) begin
                    $display("%0t run_length mismatch: expected %0d actual %0d",
                             $time, want.run_length, m_run_length);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
